// ===== rtl/core/tnrf_pkg.sv =====
package tnrf_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_EC   = 8'd247;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_BS   = 8'h08;

  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  localparam logic [7:0] DEF_WIDTH  = 8'd80;
  localparam logic [7:0] DEF_HEIGHT = 8'd25;

  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;

  localparam logic [2:0] SUB_POS_WIDTH  = 3'd2;
  localparam logic [2:0] SUB_POS_HEIGHT = 3'd4;
  localparam logic [2:0] SUB_POS_LAST   = 3'd5;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_WINSZ  = 3'd1,
    KIND_TTYPE  = 3'd2,
    KIND_DISC   = 3'd3,
    KIND_REPLY  = 3'd4
  } kind_t;

  localparam logic [2:0] ADDR_DEF_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_DEF_HEIGHT = 3'd4;

endpackage

// ===== rtl/core/telnet_receive_filter_unit.sv =====
// telnet receive filter
// in_*  : stream of received telnet bytes, one byte per beat on in_tdata
// out_* : filtered events; out_tuser carries the event kind, out_tdata
//         carries the data or reply byte and the current window size
// cfg_* : register port, default width at address 0, default height at 4;
//         the user writes it only while the stream is idle; the block itself does not enforce this
// each accepted byte gives one event or none. the event is registered and appears
// on the output register in the cycle after the byte is taken
// a new byte is taken every cycle as long as the output
// register is empty or being emptied in the same cycle; the single output
// register is what limits the rate when the receiver stalls
// while out_tready is low with an event held, in_tready drops and the
// parser state holds
// reset clears the parser to the data phase, the window size to 80 x 25
// and the defaults to 80 and 25; no event is pending after reset
module telnet_receive_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_value, win_width, win_height
  output logic [2:0]  out_tuser,  // event_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_OPT    = 3'd2,
    PH_SUB    = 3'd3,
    PH_SUBIAC = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  verb_r, verb_nxt;
  logic [7:0]  opt_r, opt_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  width_r, width_nxt;
  logic [7:0]  height_r, height_nxt;
  logic [7:0]  def_w_r, def_h_r;

  logic        out_valid_r;
  logic [7:0]  out_val_r;
  logic [7:0]  out_w_r, out_h_r;
  tnrf_pkg::kind_t out_kind_r;

  logic        in_acc;
  logic        cfg_wr;
  logic        ev;
  logic        naws_done;
  logic [7:0]  b;
  logic [7:0]  val;
  logic [7:0]  verb_full;
  tnrf_pkg::kind_t kind;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = {24'd0, cfg_paddr[2] ? def_h_r : def_w_r};

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign verb_full  = b - tnrf_pkg::B_WILL;

  always_comb begin
    phase_nxt  = phase_r;
    verb_nxt   = verb_r;
    opt_nxt    = opt_r;
    pos_nxt    = pos_r;
    hold_nxt   = hold_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    ev         = 1'b0;
    naws_done  = 1'b0;
    kind       = tnrf_pkg::KIND_DATA;
    val        = 8'd0;

    // option and size bytes are counted raw, iac included
    if (phase_r == PH_SUB || phase_r == PH_SUBIAC) begin
      if (pos_r == 3'd0) begin
        opt_nxt = b;
      end else if (opt_r == tnrf_pkg::OPT_NAWS) begin
        if (pos_r == tnrf_pkg::SUB_POS_WIDTH) begin
          hold_nxt = b;
        end else if (pos_r == tnrf_pkg::SUB_POS_HEIGHT) begin
          width_nxt  = (hold_r != 8'd0) ? hold_r : def_w_r;
          height_nxt = (b != 8'd0) ? b : def_h_r;
          naws_done  = 1'b1;
        end
      end
      if (pos_r < tnrf_pkg::SUB_POS_LAST) begin
        pos_nxt = pos_r + 3'd1;
      end
    end

    case (phase_r)
      PH_IAC: begin
        phase_nxt = PH_DATA;
        if (b == tnrf_pkg::B_IAC) begin
          ev  = 1'b1;
          val = tnrf_pkg::B_IAC;
        end else if (b >= tnrf_pkg::B_WILL) begin
          verb_nxt  = verb_full[1:0];
          phase_nxt = PH_OPT;
        end else if (b == tnrf_pkg::B_SB) begin
          pos_nxt   = 3'd0;
          opt_nxt   = 8'd0;
          hold_nxt  = 8'd0;
          phase_nxt = PH_SUB;
        end else if (b == tnrf_pkg::B_EC) begin
          ev  = 1'b1;
          val = tnrf_pkg::B_BS;
        end
      end
      PH_OPT: begin
        if (b == tnrf_pkg::OPT_TTYPE) begin
          if (verb_r == tnrf_pkg::VERB_WILL) begin
            ev   = 1'b1;
            kind = tnrf_pkg::KIND_TTYPE;
          end else if (verb_r == tnrf_pkg::VERB_WONT) begin
            ev   = 1'b1;
            kind = tnrf_pkg::KIND_DISC;
          end
        end
        verb_nxt  = 2'd0;
        phase_nxt = PH_DATA;
      end
      PH_SUB: begin
        if (b == tnrf_pkg::B_IAC) begin
          phase_nxt = PH_SUBIAC;
        end
      end
      PH_SUBIAC: begin
        if (b == tnrf_pkg::B_SE) begin
          phase_nxt = PH_DATA;
          pos_nxt   = 3'd0;
        end else begin
          ev        = 1'b1;
          kind      = tnrf_pkg::KIND_REPLY;
          val       = b;
          phase_nxt = PH_SUB;
        end
      end
      default: begin
        phase_nxt = PH_DATA;
        if (b == tnrf_pkg::B_IAC) begin
          phase_nxt = PH_IAC;
        end else begin
          ev  = 1'b1;
          val = b;
        end
      end
    endcase

    if (!ev && naws_done) begin
      ev   = 1'b1;
      kind = tnrf_pkg::KIND_WINSZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      verb_r      <= 2'd0;
      opt_r       <= 8'd0;
      pos_r       <= 3'd0;
      hold_r      <= 8'd0;
      width_r     <= tnrf_pkg::DEF_WIDTH;
      height_r    <= tnrf_pkg::DEF_HEIGHT;
      def_w_r     <= tnrf_pkg::DEF_WIDTH;
      def_h_r     <= tnrf_pkg::DEF_HEIGHT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2]) begin
          def_h_r <= cfg_pwdata[7:0];
        end else begin
          def_w_r <= cfg_pwdata[7:0];
        end
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        verb_r      <= verb_nxt;
        opt_r       <= opt_nxt;
        pos_r       <= pos_nxt;
        hold_r      <= hold_nxt;
        width_r     <= width_nxt;
        height_r    <= height_nxt;
        out_valid_r <= ev;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (in_acc && ev) begin
      out_kind_r <= kind;
      out_val_r  <= val;
      out_w_r    <= width_nxt;
      out_h_r    <= height_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_h_r, out_w_r, out_val_r};
  assign out_tuser  = out_kind_r;

endmodule

// ===== rtl/core/tnrf_checker.sv =====
module tnrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("event pending after reset");

  // held beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // empty output register never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // kinds without a byte carry zero
  a_kind_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tnrf_pkg::KIND_DATA && out_tuser != tnrf_pkg::KIND_REPLY
    |-> out_tdata[7:0] == 8'd0)
    else $error("nonzero value on size or option event");

  // out_tvalid does not rise without a beat in the cycle before
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("event without a received byte");

endmodule

bind telnet_receive_filter_unit tnrf_checker u_tnrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
